FILE: rtl/psbc_pkg.sv
// ----------------------------------------------------------------------------
// psbc_pkg: shared types and constants for the pendulum controller
// Field widths, fixed-point constants, register map, config bundle and
// saturating arithmetic helpers used across the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package psbc_pkg;

  // payload widths
  localparam int ANGLE_W   = 17;
  localparam int COUNT_W   = 32;
  localparam int GAIN_W    = 32;
  localparam int LIMIT_W   = 16;
  localparam int DRIVE_W   = 17;
  localparam int RATE_W    = 18;
  localparam int ERR_W     = 18;

  // control constants
  localparam int HOLD_TICKS = 90;
  localparam int HOLD_W     = $clog2(HOLD_TICKS + 1);
  localparam int SUM_WIDTH  = 48;
  localparam int SUM1_W     = SUM_WIDTH + 1;

  // datapath widths
  localparam int ACC_W       = 64;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int WIDE_W      = ACC_W + MUL_W;
  localparam int NUM_W       = RATE_W + 3;
  localparam int REF_SHIFT   = 12;
  localparam int REF_LIM_EXP = 40;
  localparam int REF_W       = REF_LIM_EXP + 2;
  localparam int DRIVE_SHIFT = 20;
  localparam int U_W         = ACC_W - DRIVE_SHIFT;
  localparam int DIFFC_W     = COUNT_W + 1;
  localparam int DIFFA_W     = ERR_W + 1;

  // term sequencing: two multiplier passes per term, three terms per PID
  localparam int TERM_COUNT  = 3;
  localparam int STEP_W      = 3;
  localparam logic [STEP_W-1:0] ISSUE_STEPS = STEP_W'(2 * TERM_COUNT);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(2 * TERM_COUNT + 1);

  // configuration port
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  // fixed-point constants (Q8.8 degrees and drive units)
  localparam logic signed [ERR_W-1:0] TOP_Q      = ERR_W'(46080);
  localparam logic [ANGLE_W-1:0]      COAST_Q    = ANGLE_W'(10240);
  localparam logic [ANGLE_W-1:0]      QUARTER_Q  = ANGLE_W'(23040);
  localparam logic [ANGLE_W-1:0]      THREE_Q    = ANGLE_W'(69120);
  localparam logic signed [U_W-1:0]   PUMP_DRIVE = U_W'(7680);
  localparam logic signed [U_W-1:0]   COAST_DRIVE = U_W'(6400);

  // divide by five through a reciprocal multiply
  localparam logic [MUL_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int               RECIP5_SHIFT = 34;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] REF_LIM_POS = ACC_W'(64'sd1 <<< REF_LIM_EXP);
  localparam logic signed [ACC_W-1:0] REF_LIM_NEG = -REF_LIM_POS;
  localparam logic signed [REF_W-1:0] ERR_MAX_R = REF_W'(131071);
  localparam logic signed [REF_W-1:0] ERR_MIN_R = -REF_W'(131072);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANGLE_KP,
    REG_ANGLE_KD,
    REG_ANGLE_KI,
    REG_CART_KP,
    REG_CART_KD,
    REG_CART_KI,
    REG_ENTRY_ANGLE,
    REG_DRIVE_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  angle_kp;
    logic [GAIN_W-1:0]  angle_kd;
    logic [GAIN_W-1:0]  angle_ki;
    logic [GAIN_W-1:0]  cart_kp;
    logic [GAIN_W-1:0]  cart_kd;
    logic [GAIN_W-1:0]  cart_ki;
    logic [LIMIT_W-1:0] entry_angle;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    angle_kp:    32'd26214400,
    angle_kd:    32'd943718,
    angle_ki:    32'd0,
    cart_kp:     32'd524,
    cart_kd:     32'd0,
    cart_ki:     32'd0,
    entry_angle: 16'd3840,
    drive_limit: 16'd12288
  };

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      balancing;
    logic                      coasting;
  } result_t;

  // signed add that pins to the 64-bit range
  function automatic logic signed [ACC_W-1:0] sat_add_acc(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W + 1)'(a) + (ACC_W + 1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // integrator update, pinned to the integrator width
  function automatic logic signed [SUM_WIDTH-1:0] sat_sum(
    input logic signed [SUM_WIDTH-1:0] sum,
    input logic signed [COUNT_W-1:0]   x
  );
    logic signed [SUM_WIDTH:0] s;
    s = SUM1_W'(sum) + SUM1_W'(x);
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
      return s[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psbc_sample_if.sv
// ----------------------------------------------------------------------------
// psbc_sample_if: sensor sample channel
// Valid/ready channel carrying one pendulum angle and cart count per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface psbc_sample_if import psbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] pend_angle;
  logic signed [COUNT_W-1:0] cart_count;

  modport source (output valid, output pend_angle, output cart_count, input ready);
  modport sink   (input valid, input pend_angle, input cart_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/psbc_command_if.sv
// ----------------------------------------------------------------------------
// psbc_command_if: drive command channel
// Valid/ready channel carrying the drive command and mode flags per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface psbc_command_if import psbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      balancing;
  logic                      coasting;

  modport source (output valid, output drive, output balancing, output coasting,
                  input ready);
  modport sink   (input valid, input drive, input balancing, input coasting,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/pendulum_swingup_balance_control.sv
// ----------------------------------------------------------------------------
// pendulum_swingup_balance_control: swing-up and cascaded PID balance
// Takes one angle/encoder sample per beat and returns one drive command.
// ----------------------------------------------------------------------------
// Swing-up steps through the rate, divide (skipped for the first sample),
//   mode and finish states; balance runs both PIDs between mode and finish
//   on the one shared multiplier (two 32x32 passes per term, six terms).
//   No sample is taken until the last has left the finish state, and a
//   finished command waits in the output register while the next sample
//   is taken. Reset (rst, synchronous) clears all controller state and loads
//   the register defaults; the block is ready in the first cycle after reset.
`default_nettype none

module pendulum_swingup_balance_control import psbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  psbc_sample_if.sink       sample,
  psbc_command_if.source    command,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  logic              seq_idle;
  logic              start;
  logic              res_take;
  logic              res_done;
  result_t           res;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              out_valid;
  result_t           out_data;

  psbc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psbc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  psbc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .pend_angle (sample.pend_angle),
    .cart_count (sample.cart_count),
    .idle       (seq_idle),
    .res_take   (res_take),
    .res_done   (res_done),
    .res        (res),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p)
  );

  assign sample.ready = seq_idle;
  assign start        = sample.valid && seq_idle;
  assign res_take     = !out_valid || command.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done) begin
      out_valid <= 1'b1;
    end else if (command.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_done) begin
      out_data <= res;
    end
  end

  assign command.valid     = out_valid;
  assign command.drive     = out_data.drive;
  assign command.balancing = out_data.balancing;
  assign command.coasting  = out_data.coasting;

endmodule

`default_nettype wire

FILE: rtl/psbc_apb_regs.sv
// ----------------------------------------------------------------------------
// psbc_apb_regs: configuration register file
// APB-style write/read access to the PID gains, entry angle and drive limit.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_apb_regs import psbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  cfg_reg_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ANGLE_KP:    cfg.angle_kp    <= pwdata[GAIN_W-1:0];
        REG_ANGLE_KD:    cfg.angle_kd    <= pwdata[GAIN_W-1:0];
        REG_ANGLE_KI:    cfg.angle_ki    <= pwdata[GAIN_W-1:0];
        REG_CART_KP:     cfg.cart_kp     <= pwdata[GAIN_W-1:0];
        REG_CART_KD:     cfg.cart_kd     <= pwdata[GAIN_W-1:0];
        REG_CART_KI:     cfg.cart_ki     <= pwdata[GAIN_W-1:0];
        REG_ENTRY_ANGLE: cfg.entry_angle <= pwdata[LIMIT_W-1:0];
        REG_DRIVE_LIMIT: cfg.drive_limit <= pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_KP:    prdata = APB_DW'(cfg.angle_kp);
      REG_ANGLE_KD:    prdata = APB_DW'(cfg.angle_kd);
      REG_ANGLE_KI:    prdata = APB_DW'(cfg.angle_ki);
      REG_CART_KP:     prdata = APB_DW'(cfg.cart_kp);
      REG_CART_KD:     prdata = APB_DW'(cfg.cart_kd);
      REG_CART_KI:     prdata = APB_DW'(cfg.cart_ki);
      REG_ENTRY_ANGLE: prdata = APB_DW'(cfg.entry_angle);
      REG_DRIVE_LIMIT: prdata = APB_DW'(cfg.drive_limit);
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/psbc_mul.sv
// ----------------------------------------------------------------------------
// psbc_mul: shared multiplier
// Unsigned 32x32 multiply with a registered 64-bit product, one result
// per cycle, in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_mul import psbc_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

FILE: rtl/psbc_seq.sv
// ----------------------------------------------------------------------------
// psbc_seq: control sequencer and datapath
// Rate filter, swing-up logic and the cascaded cart/angle PID, with every
// multiply issued to the shared multiplier under a small state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_seq import psbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      start,
  input  logic signed [ANGLE_W-1:0] pend_angle,
  input  logic signed [COUNT_W-1:0] cart_count,
  output logic                      idle,
  input  logic                      res_take,
  output logic                      res_done,
  output result_t                   res,
  output logic [MUL_W-1:0]          mul_a,
  output logic [MUL_W-1:0]          mul_b,
  input  logic [PROD_W-1:0]         mul_p
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,
    S_DIV,
    S_MODE,
    S_CSUM,
    S_CART,
    S_REF,
    S_ASUM,
    S_ANGLE,
    S_DRIVE,
    S_FINISH
  } state_t;

  state_t state;

  // latched sample
  logic signed [ANGLE_W-1:0] angle;
  logic signed [COUNT_W-1:0] xe;

  // controller state
  logic                        primed;
  logic signed [ANGLE_W-1:0]   last_angle;
  logic signed [RATE_W-1:0]    angle_rate;
  logic                        balance_on;
  logic                        phase_coast;
  logic [HOLD_W-1:0]           hold_count;
  logic                        push_negative;
  logic signed [ERR_W-1:0]     prior_angle_error;
  logic signed [SUM_WIDTH-1:0] angle_error_sum;
  logic signed [COUNT_W-1:0]   prior_cart_error;
  logic signed [SUM_WIDTH-1:0] cart_error_sum;

  // working registers
  logic                      rate_neg;
  logic [STEP_W-1:0]         step;
  logic [PROD_W-1:0]         lo_p;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc;
  logic                      neg_issue;
  logic                      neg_form;
  logic signed [ERR_W-1:0]   err;
  logic signed [U_W-1:0]     u;

  // combinational
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          num_mag;
  logic signed [RATE_W-1:0]  rate_q;
  logic signed [ERR_W-1:0]   e_top;
  logic [ANGLE_W-1:0]        abs_e;
  logic [ANGLE_W-1:0]        abs_angle;
  logic                      enter;
  logic                      cs_pos;
  logic                      cs_neg;
  logic                      positive;
  logic                      coast_next;
  logic [HOLD_W-1:0]         hold_next;
  logic                      push_next;
  logic signed [U_W-1:0]     swing_mag;
  logic signed [U_W-1:0]     u_swing;
  logic                      angle_grp;
  logic                      pid_run;
  logic [1:0]                ti;
  logic [GAIN_W-1:0]         term_gain;
  logic signed [ACC_W-1:0]   term_val;
  logic [ACC_W-1:0]          term_mag;
  logic [WIDE_W-1:0]         wide;
  logic                      ovf_pos;
  logic                      ovf_neg;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   ref_full;
  logic signed [REF_W-1:0]   ref_c;
  logic signed [REF_W-1:0]   err_w;
  logic signed [ERR_W-1:0]   err_sat;
  logic signed [U_W-1:0]     lim_s;
  logic signed [U_W-1:0]     u_c;

  // rate filter numerator and the divided result
  always_comb begin
    num     = (NUM_W'(angle_rate) <<< 2) + NUM_W'(angle) - NUM_W'(last_angle);
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rate_q  = $signed(mul_p[RECIP5_SHIFT +: RATE_W]);
  end

  // distance from the top, and the cosine sign
  always_comb begin
    e_top     = angle[ANGLE_W-1] ? ERR_W'(angle) + TOP_Q : ERR_W'(angle) - TOP_Q;
    abs_e     = e_top[ERR_W-1] ? ANGLE_W'(-e_top) : ANGLE_W'(e_top);
    abs_angle = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
    enter     = !balance_on && (abs_e < ANGLE_W'(cfg.entry_angle));
    cs_pos    = (abs_angle < QUARTER_Q) || (abs_angle > THREE_Q);
    cs_neg    = (abs_angle > QUARTER_Q) && (abs_angle < THREE_Q);
    positive  = (!angle_rate[RATE_W-1] && (angle_rate != '0) && cs_pos)
             || (angle_rate[RATE_W-1] && cs_neg);
  end

  // swing-up: pump with a held direction, or coast following the sign
  always_comb begin
    coast_next = phase_coast || (abs_e < COAST_Q);
    hold_next  = hold_count;
    push_next  = push_negative;
    if (coast_next) begin
      swing_mag = COAST_DRIVE;
      push_next = !positive;
      if (!phase_coast) begin
        hold_next = '0;
      end
    end else begin
      swing_mag = PUMP_DRIVE;
      if (hold_count < HOLD_W'(HOLD_TICKS)) begin
        hold_next = hold_count + HOLD_W'(1);
      end else begin
        push_next = !positive;
        hold_next = '0;
      end
    end
    u_swing = push_next ? -swing_mag : swing_mag;
  end

  // PID term select: proportional, derivative, integral
  always_comb begin
    angle_grp = (state == S_ANGLE);
    pid_run   = (state == S_CART) || (state == S_ANGLE);
    ti        = step[2:1];
    if (angle_grp) begin
      case (ti)
        2'd0: begin
          term_gain = cfg.angle_kp;
          term_val  = ACC_W'(err);
        end
        2'd1: begin
          term_gain = cfg.angle_kd;
          term_val  = ACC_W'(DIFFA_W'(err) - DIFFA_W'(prior_angle_error));
        end
        default: begin
          term_gain = cfg.angle_ki;
          term_val  = ACC_W'(angle_error_sum);
        end
      endcase
    end else begin
      case (ti)
        2'd0: begin
          term_gain = cfg.cart_kp;
          term_val  = ACC_W'(xe);
        end
        2'd1: begin
          term_gain = cfg.cart_kd;
          term_val  = ACC_W'(DIFFC_W'(xe) - DIFFC_W'(prior_cart_error));
        end
        default: begin
          term_gain = cfg.cart_ki;
          term_val  = ACC_W'(cart_error_sum);
        end
      endcase
    end
    term_mag = term_val[ACC_W-1] ? ACC_W'(-term_val) : ACC_W'(term_val);
  end

  // multiplier operands: low half then high half of each term magnitude
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_RATE) begin
      mul_a = MUL_W'(num_mag);
      mul_b = RECIP5;
    end else if (pid_run && (step < ISSUE_STEPS)) begin
      mul_a = term_gain;
      mul_b = step[0] ? term_mag[ACC_W-1:MUL_W] : term_mag[MUL_W-1:0];
    end
  end

  // join partial products and pin to the signed 64-bit range
  always_comb begin
    wide    = (WIDE_W'(mul_p) << MUL_W) + WIDE_W'(lo_p);
    ovf_pos = (wide[WIDE_W-1:ACC_W-1] != '0);
    ovf_neg = (wide[WIDE_W-1:ACC_W] != '0)
           || (wide[ACC_W-1] && (wide[ACC_W-2:0] != '0));
    if (neg_form) begin
      prod = ovf_neg ? ACC_MIN : -$signed(wide[ACC_W-1:0]);
    end else begin
      prod = ovf_pos ? ACC_MAX : $signed(wide[ACC_W-1:0]);
    end
  end

  // cart output becomes the angle reference
  always_comb begin
    ref_full = acc >>> REF_SHIFT;
    if (ref_full > REF_LIM_POS) begin
      ref_c = REF_W'(REF_LIM_POS);
    end else if (ref_full < REF_LIM_NEG) begin
      ref_c = REF_W'(REF_LIM_NEG);
    end else begin
      ref_c = REF_W'(ref_full);
    end
    err_w = REF_W'(e_top) - ref_c;
    if (err_w > ERR_MAX_R) begin
      err_sat = ERR_W'(ERR_MAX_R);
    end else if (err_w < ERR_MIN_R) begin
      err_sat = ERR_W'(ERR_MIN_R);
    end else begin
      err_sat = ERR_W'(err_w);
    end
  end

  // drive saturation and result
  always_comb begin
    lim_s = U_W'(cfg.drive_limit);
    if (u > lim_s) begin
      u_c = lim_s;
    end else if (u < -lim_s) begin
      u_c = -lim_s;
    end else begin
      u_c = u;
    end
    res.drive     = DRIVE_W'(u_c);
    res.balancing = balance_on;
    res.coasting  = !balance_on && phase_coast;
    idle          = (state == S_IDLE);
    res_done      = (state == S_FINISH) && res_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      primed            <= 1'b0;
      last_angle        <= '0;
      angle_rate        <= '0;
      balance_on        <= 1'b0;
      phase_coast       <= 1'b0;
      hold_count        <= '0;
      push_negative     <= 1'b0;
      prior_angle_error <= '0;
      angle_error_sum   <= '0;
      prior_cart_error  <= '0;
      cart_error_sum    <= '0;
      rate_neg          <= 1'b0;
      step              <= '0;
      neg_issue         <= 1'b0;
      neg_form          <= 1'b0;
      err               <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            angle <= pend_angle;
            xe    <= cart_count;
            state <= S_RATE;
          end
        end
        S_RATE: begin
          last_angle <= angle;
          if (primed) begin
            rate_neg <= num[NUM_W-1];
            state    <= S_DIV;
          end else begin
            // first sample only seeds the filter
            primed <= 1'b1;
            state  <= S_MODE;
          end
        end
        S_DIV: begin
          angle_rate <= rate_neg ? -rate_q : rate_q;
          state      <= S_MODE;
        end
        S_MODE: begin
          if (enter) begin
            balance_on        <= 1'b1;
            prior_angle_error <= e_top;
            angle_error_sum   <= '0;
            prior_cart_error  <= xe;
            cart_error_sum    <= '0;
            state             <= S_CSUM;
          end else if (balance_on) begin
            state <= S_CSUM;
          end else begin
            phase_coast   <= coast_next;
            hold_count    <= hold_next;
            push_negative <= push_next;
            u             <= u_swing;
            state         <= S_FINISH;
          end
        end
        S_CSUM: begin
          cart_error_sum <= sat_sum(cart_error_sum, xe);
          acc            <= '0;
          step           <= '0;
          state          <= S_CART;
        end
        S_CART, S_ANGLE: begin
          step <= step + STEP_W'(1);
          if (step[0]) begin
            // low partial product is back; pass the sign down the pipe
            lo_p     <= mul_p;
            neg_form <= neg_issue;
            if (step != STEP_W'(1)) begin
              acc <= sat_add_acc(acc, term);
            end
          end else begin
            if (step < ISSUE_STEPS) begin
              neg_issue <= term_val[ACC_W-1];
            end
            if (step != '0) begin
              term <= prod;
            end
          end
          if (step == STEP_LAST) begin
            state <= (state == S_CART) ? S_REF : S_DRIVE;
          end
        end
        S_REF: begin
          err   <= err_sat;
          state <= S_ASUM;
        end
        S_ASUM: begin
          angle_error_sum <= sat_sum(angle_error_sum, COUNT_W'(err));
          acc             <= '0;
          step            <= '0;
          state           <= S_ANGLE;
        end
        S_DRIVE: begin
          u                 <= U_W'(acc >>> DRIVE_SHIFT);
          prior_angle_error <= err;
          prior_cart_error  <= xe;
          state             <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_balance_sticky: assert property (@(posedge clk) disable iff (rst)
    balance_on |=> balance_on)
    else $error("balance mode left");

  a_coast_sticky: assert property (@(posedge clk) disable iff (rst)
    phase_coast |=> phase_coast)
    else $error("coast phase returned to pump");

  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    hold_count <= HOLD_W'(HOLD_TICKS))
    else $error("hold counter past hold length");

  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    res_done |-> ((U_W'(res.drive) <= lim_s) && (U_W'(res.drive) >= -lim_s)))
    else $error("drive outside limit");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("sample taken while busy");
`endif

endmodule

`default_nettype wire
